@@ rtl/core/grw_pkg.sv @@
package grw_pkg;

  localparam int GRID_DIM_DEF  = 1024;
  localparam int RANGE_CAP_DEF = 16;

  localparam int CELL_W     = 12;
  localparam int COORD_W    = 18;
  localparam int HEAD_W     = 16;
  localparam int GW_W       = 11;
  localparam int RANGE_W    = 5;
  localparam int INDEX_W    = 21;
  localparam int SEG_W      = 15;
  localparam int UNIT_W     = 24;
  localparam int MAG_W      = 17;
  localparam int CORDIC_W   = 20;
  localparam int ANGLE_W    = 18;
  localparam int ITER_W     = 4;
  localparam int COUNT_W    = 6;

  localparam int CORDIC_ITERS = 14;
  localparam int CORDIC_X0    = 39797;
  localparam int Q16_ONE      = 65536;
  localparam int CELL_CAP     = 64;

  localparam logic [UNIT_W-1:0] DIST_MAX = {UNIT_W{1'b1}};
  localparam logic [SEG_W-1:0]  SEG_MAX  = {SEG_W{1'b1}};

  // register indexes
  localparam logic REG_GRID_WIDTH = 1'b0;
  localparam logic REG_RAY_RANGE  = 1'b1;

  // cordic angle table in heading units
  function automatic logic [13:0] atan_units(input logic [ITER_W-1:0] i);
    logic [13:0] v;
    case (i)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/grw_if.sv @@
interface grw_in_if;
  logic                         valid;
  logic                         ready;
  logic [grw_pkg::COORD_W-1:0]  start_x;
  logic [grw_pkg::COORD_W-1:0]  start_y;
  logic [grw_pkg::HEAD_W-1:0]   heading;

  modport source (output valid, start_x, start_y, heading, input ready);
  modport sink   (input valid, start_x, start_y, heading, output ready);
endinterface

interface grw_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [grw_pkg::INDEX_W-1:0]  cell_index;
  logic [grw_pkg::SEG_W-1:0]           segment_length;
  logic                                last_cell;

  modport source (output valid, cell_index, segment_length, last_cell, input ready);
  modport sink   (input valid, cell_index, segment_length, last_cell, output ready);
endinterface

@@ rtl/core/grw_recip.sv @@
// iterative reciprocal 2^30 / divisor, one quotient bit per cycle
module grw_recip (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [grw_pkg::MAG_W-1:0]     divisor,
  output logic                          done,
  output logic [grw_pkg::UNIT_W-1:0]    quotient
);

  localparam int REM_W = grw_pkg::MAG_W + 1;
  // divisors at or below this give a quotient past the saturation limit
  localparam int SAT_DIV = 64;

  logic                        busy_r;
  logic                        done_r;
  logic [4:0]                  cnt_r;
  logic [REM_W-1:0]            rem_r;
  logic [grw_pkg::MAG_W-1:0]   div_r;
  logic [grw_pkg::UNIT_W-1:0]  q_r;
  logic [REM_W:0]              rem_sh;
  logic                        qbit;

  assign rem_sh = {rem_r, 1'b0};
  assign qbit   = rem_sh >= {2'b00, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if ({15'd0, divisor} <= 32'(SAT_DIV)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == 5'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem_r <= REM_W'(SAT_DIV);
      cnt_r <= 5'(grw_pkg::UNIT_W - 1);
      q_r   <= grw_pkg::DIST_MAX;
    end else if (busy_r) begin
      rem_r <= qbit ? REM_W'(rem_sh - {2'b00, div_r}) : rem_sh[REM_W-1:0];
      q_r   <= {q_r[grw_pkg::UNIT_W-2:0], qbit};
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ rtl/core/grid_ray_cell_walker_top.sv @@
// sequence: the first cell follows 14 cordic rotations, clamp, prep, two reciprocals
//   in one shared divider and two boundary distances on one shared multiplier;
//   shorter when a reciprocal saturates or the heading is on an axis
// flow: a ray yields up to 64 cells; one cell per cycle while the receiver keeps up;
//   not ready while busy, so a new ray is taken only after the last walk ends
// reset: synchronous active-low rst_n, grid_width back to 1024, ray_range to 8, idle
module grid_ray_cell_walker_top #(
  parameter int GRID_DIM  = grw_pkg::GRID_DIM_DEF,
  parameter int RANGE_CAP = grw_pkg::RANGE_CAP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  grw_in_if.sink                      in_ray,
  grw_out_if.source                   out_cell,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [grw_pkg::GW_W-1:0]    cfg_data
);

  localparam int CW = grw_pkg::CELL_W;
  localparam int XW = grw_pkg::CORDIC_W;
  localparam int AW = grw_pkg::ANGLE_W;
  localparam int UW = grw_pkg::UNIT_W;

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ROT   = 4'd1;
  localparam logic [3:0] S_CLAMP = 4'd2;
  localparam logic [3:0] S_PREP  = 4'd3;
  localparam logic [3:0] S_DIVX  = 4'd4;
  localparam logic [3:0] S_DIVY  = 4'd5;
  localparam logic [3:0] S_DSTX  = 4'd6;
  localparam logic [3:0] S_DSTY  = 4'd7;
  localparam logic [3:0] S_WALK  = 4'd8;

  // configuration registers
  logic [grw_pkg::GW_W-1:0]    grid_width_r;
  logic [grw_pkg::RANGE_W-1:0] ray_range_r;

  logic [3:0]                  state_r;
  logic [grw_pkg::COORD_W-1:0] sx_r, sy_r;
  logic [grw_pkg::RANGE_W-1:0] rng_r;
  logic [grw_pkg::GW_W-1:0]    gw_r;

  // cordic datapath, reused to hold clamped cos and sin
  logic signed [XW-1:0]        x_r, y_r;
  logic signed [AW-1:0]        a_r;
  logic [grw_pkg::ITER_W-1:0]  iter_r;
  logic                        neg_r;

  logic [UW-1:0]               unit_x_r, unit_y_r;
  logic [UW-1:0]               dist_x_r, dist_y_r;
  logic [1:0]                  step_signs_r;
  logic signed [CW-1:0]        cell_x_r, cell_y_r;
  logic signed [CW-1:0]        lo_x_r, lo_y_r, hi_x_r, hi_y_r;
  logic [grw_pkg::COUNT_W-1:0] count_r;

  // output register
  logic                        out_valid_r;
  logic signed [grw_pkg::INDEX_W-1:0] cell_index_r;
  logic [grw_pkg::SEG_W-1:0]   segment_r;
  logic                        last_r;

  // effective config values, saturated by the build limits
  logic [grw_pkg::GW_W-1:0]    gw_eff;
  logic [grw_pkg::RANGE_W-1:0] rng_eff;

  assign gw_eff  = (32'(grid_width_r) > GRID_DIM) ? grw_pkg::GW_W'(GRID_DIM) : grid_width_r;
  assign rng_eff = (32'(ray_range_r) > RANGE_CAP) ? grw_pkg::RANGE_W'(RANGE_CAP)
                                                  : ray_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= grw_pkg::GW_W'(1024);
      ray_range_r  <= grw_pkg::RANGE_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        grw_pkg::REG_GRID_WIDTH: grid_width_r <= cfg_data;
        grw_pkg::REG_RAY_RANGE:  ray_range_r  <= cfg_data[grw_pkg::RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- cordic rotation step (one shared add/sub/shift unit) ----
  logic signed [XW-1:0] sh_x, sh_y;
  logic signed [AW-1:0] atan_step;

  assign sh_x      = x_r >>> iter_r;
  assign sh_y      = y_r >>> iter_r;
  assign atan_step = AW'({4'd0, grw_pkg::atan_units(iter_r)});

  // angle fold of the incoming heading
  logic signed [AW-1:0] a_in;
  logic signed [AW-1:0] a_fold;
  logic                 fold;

  assign a_in   = AW'($signed(in_ray.heading));
  assign fold   = (a_in > AW'(16384)) || (a_in < -AW'(16384));
  assign a_fold = (a_in > AW'(16384)) ? a_in - AW'(32768) :
                  (a_in < -AW'(16384)) ? a_in + AW'(32768) : a_in;

  // clamp after optional negation
  logic signed [XW-1:0] xn, yn, xc, yc;

  assign xn = neg_r ? -x_r : x_r;
  assign yn = neg_r ? -y_r : y_r;
  assign xc = (xn > XW'(grw_pkg::Q16_ONE)) ? XW'(grw_pkg::Q16_ONE) :
              (xn < -XW'(grw_pkg::Q16_ONE)) ? -XW'(grw_pkg::Q16_ONE) : xn;
  assign yc = (yn > XW'(grw_pkg::Q16_ONE)) ? XW'(grw_pkg::Q16_ONE) :
              (yn < -XW'(grw_pkg::Q16_ONE)) ? -XW'(grw_pkg::Q16_ONE) : yn;

  // magnitudes for the reciprocal unit
  logic [XW-1:0]              abs_x, abs_y;
  logic                       div_start;
  logic [grw_pkg::MAG_W-1:0]  div_divisor;
  logic                       div_done;
  logic [UW-1:0]              div_q;

  assign abs_x       = x_r[XW-1] ? XW'(-x_r) : XW'(x_r);
  assign abs_y       = y_r[XW-1] ? XW'(-y_r) : XW'(y_r);
  assign div_start   = (state_r == S_PREP) || (state_r == S_DIVX && div_done);
  assign div_divisor = (state_r == S_PREP) ? abs_x[grw_pkg::MAG_W-1:0]
                                           : abs_y[grw_pkg::MAG_W-1:0];

  grw_recip u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // first boundary distance, one shared multiplier for both axes
  logic                 dst_is_x;
  logic [UW-1:0]        mul_unit;
  logic [8:0]           frac;
  logic [UW+8:0]        prod;
  logic [UW:0]          dist_raw;
  logic [UW-1:0]        dist_sat;
  logic                 comp_zero;

  assign dst_is_x  = (state_r == S_DSTX);
  assign mul_unit  = dst_is_x ? unit_x_r : unit_y_r;
  assign frac      = dst_is_x ?
                     (step_signs_r[0] ? 9'd256 - {1'b0, sx_r[7:0]} : {1'b0, sx_r[7:0]}) :
                     (step_signs_r[1] ? 9'd256 - {1'b0, sy_r[7:0]} : {1'b0, sy_r[7:0]});
  assign prod      = mul_unit * frac;
  assign dist_raw  = prod[UW+8:8];
  assign comp_zero = dst_is_x ? (x_r == '0) : (y_r == '0);
  assign dist_sat  = (comp_zero || dist_raw[UW]) ? grw_pkg::DIST_MAX : dist_raw[UW-1:0];

  // lower window bound, truncated toward zero
  function automatic logic signed [CW-1:0] low_bound(input logic [grw_pkg::COORD_W-1:0] c,
                                                     input logic [grw_pkg::RANGE_W-1:0] r);
    logic signed [grw_pkg::COORD_W:0] v;
    logic signed [grw_pkg::COORD_W:0] nv;
    v  = $signed({1'b0, c}) - $signed({6'd0, r, 8'd0});
    nv = -v;
    if (!v[grw_pkg::COORD_W]) return CW'(v >>> 8);
    return -CW'(nv >>> 8);
  endfunction

  // ---- walk datapath ----
  logic [UW-1:0]        w, dxn, dyn, dx_nxt, dy_nxt;
  logic signed [CW-1:0] cx_nxt, cy_nxt;
  logic                 inside_cur, inside_nxt, walk_go, emit, last_nxt;
  logic signed [2*CW-1:0] idx_full;

  assign w      = (dist_x_r < dist_y_r) ? dist_x_r : dist_y_r;
  assign dxn    = dist_x_r - w;
  assign dyn    = dist_y_r - w;
  assign dx_nxt = (dxn == '0) ? unit_x_r : dxn;
  assign dy_nxt = (dyn == '0) ? unit_y_r : dyn;
  assign cx_nxt = (dxn == '0) ? (step_signs_r[0] ? cell_x_r + CW'(1) : cell_x_r - CW'(1))
                              : cell_x_r;
  assign cy_nxt = (dyn == '0) ? (step_signs_r[1] ? cell_y_r + CW'(1) : cell_y_r - CW'(1))
                              : cell_y_r;

  assign inside_cur = (cell_x_r >= lo_x_r) && (cell_x_r < hi_x_r) &&
                      (cell_y_r >= lo_y_r) && (cell_y_r < hi_y_r);
  assign inside_nxt = (cx_nxt >= lo_x_r) && (cx_nxt < hi_x_r) &&
                      (cy_nxt >= lo_y_r) && (cy_nxt < hi_y_r);
  // the cap counts emitted cells; the 64th one closes the run
  assign last_nxt   = !inside_nxt || (count_r == grw_pkg::COUNT_W'(grw_pkg::CELL_CAP - 1));

  assign walk_go  = (state_r == S_WALK) && (!out_valid_r || out_cell.ready);
  assign emit     = walk_go && inside_cur;
  // index wraps to the output width
  assign idx_full = cell_y_r * $signed({1'b0, gw_r}) + (2*CW)'(cell_x_r);

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE:  if (in_ray.valid) begin
          state_r <= (in_ray.heading[13:0] == 14'd0) ? S_CLAMP : S_ROT;
        end
        S_ROT:   if (iter_r == grw_pkg::ITER_W'(grw_pkg::CORDIC_ITERS - 1)) begin
          state_r <= S_CLAMP;
        end
        S_CLAMP: state_r <= S_PREP;
        S_PREP:  state_r <= S_DIVX;
        S_DIVX:  if (div_done) state_r <= S_DIVY;
        S_DIVY:  if (div_done) state_r <= S_DSTX;
        S_DSTX:  state_r <= S_DSTY;
        S_DSTY:  state_r <= S_WALK;
        S_WALK:  if (walk_go && (!inside_cur || last_nxt)) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase

      if (emit) out_valid_r <= 1'b1;
      else if (out_cell.ready) out_valid_r <= 1'b0;
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        sx_r   <= in_ray.start_x;
        sy_r   <= in_ray.start_y;
        rng_r  <= rng_eff;
        gw_r   <= gw_eff;
        iter_r <= '0;
        if (in_ray.heading[13:0] == 14'd0) begin
          // exact quadrant headings skip the rotation
          neg_r <= 1'b0;
          case (in_ray.heading[15:14])
            2'd0:    begin x_r <= XW'(grw_pkg::Q16_ONE);  y_r <= '0; end
            2'd1:    begin x_r <= '0; y_r <= XW'(grw_pkg::Q16_ONE);  end
            2'd2:    begin x_r <= -XW'(grw_pkg::Q16_ONE); y_r <= '0; end
            default: begin x_r <= '0; y_r <= -XW'(grw_pkg::Q16_ONE); end
          endcase
        end else begin
          neg_r <= fold;
          a_r   <= a_fold;
          x_r   <= XW'(grw_pkg::CORDIC_X0);
          y_r   <= '0;
        end
      end
      S_ROT: begin
        if (!a_r[AW-1]) begin
          x_r <= x_r - sh_y;
          y_r <= y_r + sh_x;
          a_r <= a_r - atan_step;
        end else begin
          x_r <= x_r + sh_y;
          y_r <= y_r - sh_x;
          a_r <= a_r + atan_step;
        end
        iter_r <= iter_r + grw_pkg::ITER_W'(1);
      end
      S_CLAMP: begin
        x_r <= xc;
        y_r <= yc;
      end
      S_PREP: begin
        step_signs_r <= {(y_r > 0), (x_r > 0)};
      end
      S_DIVX: if (div_done) unit_x_r <= div_q;
      S_DIVY: if (div_done) unit_y_r <= div_q;
      S_DSTX: dist_x_r <= dist_sat;
      S_DSTY: begin
        dist_y_r <= dist_sat;
        cell_x_r <= CW'({2'b00, sx_r[grw_pkg::COORD_W-1:8]});
        cell_y_r <= CW'({2'b00, sy_r[grw_pkg::COORD_W-1:8]});
        lo_x_r   <= low_bound(sx_r, rng_r);
        lo_y_r   <= low_bound(sy_r, rng_r);
        hi_x_r   <= CW'({2'b00, sx_r[grw_pkg::COORD_W-1:8]}) + CW'(rng_r);
        hi_y_r   <= CW'({2'b00, sy_r[grw_pkg::COORD_W-1:8]}) + CW'(rng_r);
        count_r  <= '0;
      end
      S_WALK: if (emit) begin
        dist_x_r <= dx_nxt;
        dist_y_r <= dy_nxt;
        cell_x_r <= cx_nxt;
        cell_y_r <= cy_nxt;
        count_r  <= count_r + grw_pkg::COUNT_W'(1);
      end
      default: ;
    endcase

    // output payload, loaded on each transfer-producing step
    if (emit) begin
      cell_index_r <= idx_full[grw_pkg::INDEX_W-1:0];
      segment_r    <= (w > UW'(grw_pkg::SEG_MAX)) ? grw_pkg::SEG_MAX : w[grw_pkg::SEG_W-1:0];
      last_r       <= last_nxt;
    end
  end

  assign in_ray.ready            = (state_r == S_IDLE);
  assign out_cell.valid          = out_valid_r;
  assign out_cell.cell_index     = cell_index_r;
  assign out_cell.segment_length = segment_r;
  assign out_cell.last_cell      = last_r;

endmodule

@@ tb/grid_ray_cell_walker_top_test.sv @@
module grid_ray_cell_walker_top_test;

  // one predicted cell of a ray walk
  typedef struct packed {
    logic signed [grw_pkg::INDEX_W-1:0] cell_index;
    logic [grw_pkg::SEG_W-1:0]          segment_length;
    logic                               last_cell;
  } cell_t;

  localparam int IDLE_WAIT   = 200;   // setup plus a full walk, with margin
  localparam int HOLD_CYCLES = 600;   // long receiver hold-off
  localparam int STALL_LIMIT = 5000;  // cycles without any transfer

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [grw_pkg::GW_W-1:0] cfg_data;

  grw_in_if  ray_if ();
  grw_out_if cell_if ();

  grid_ray_cell_walker_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ray    (ray_if.sink),
    .out_cell  (cell_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // shadow copies of the config registers
  logic [grw_pkg::GW_W-1:0]    grid_width_q = 11'd1024;
  logic [grw_pkg::RANGE_W-1:0] ray_range_q  = 5'd8;

  cell_t cells_due[$];
  int    errors     = 0;
  int    burst_left = 0;
  bit    hold_req   = 1'b0;

  // cordic angle steps in heading units
  int atan_steps[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};

  // reciprocal distance per crossed cell, Q10.14, saturated
  function automatic int cell_pitch(input int comp);
    int m;
    int u;
    m = (comp < 0) ? -comp : comp;
    if (m == 0) return int'(grw_pkg::DIST_MAX);
    u = (1 << 30) / m;
    return (u > int'(grw_pkg::DIST_MAX)) ? int'(grw_pkg::DIST_MAX) : u;
  endfunction

  // distance to the first boundary from the origin fraction
  function automatic int boundary_dist(input int pitch, input int comp, input int coord,
                                       input bit up);
    int     frac;
    longint d;
    if (comp == 0) return int'(grw_pkg::DIST_MAX);
    frac = up ? 256 - (coord & 255) : (coord & 255);
    d = (longint'(pitch) * frac) >>> 8;
    return (d > longint'(grw_pkg::DIST_MAX)) ? int'(grw_pkg::DIST_MAX) : int'(d);
  endfunction

  // computes the cells a ray visits inside the window, up to the cap, and queues them
  task automatic walk_ray(input logic [grw_pkg::COORD_W-1:0] sx,
                          input logic [grw_pkg::COORD_W-1:0] sy,
                          input logic [grw_pkg::HEAD_W-1:0] h);
    int c, s, a, x, y, t, i, q;
    bit neg;
    int r, gw;
    int ux, uy, dx, dy, w;
    int cx, cy, lo_x, lo_y, hi_x, hi_y, stx, sty, cnt, v, idx;
    bit up_x, up_y;
    cell_t pred;
    neg = 1'b0;
    r  = (ray_range_q > grw_pkg::RANGE_CAP_DEF) ? grw_pkg::RANGE_CAP_DEF : int'(ray_range_q);
    gw = (grid_width_q > grw_pkg::GRID_DIM_DEF) ? grw_pkg::GRID_DIM_DEF : int'(grid_width_q);
    if (h[13:0] == 14'd0) begin
      // axis headings are exact
      q = h[15:14];
      c = (q == 0) ? grw_pkg::Q16_ONE : (q == 2) ? -grw_pkg::Q16_ONE : 0;
      s = (q == 1) ? grw_pkg::Q16_ONE : (q == 3) ? -grw_pkg::Q16_ONE : 0;
    end else begin
      a = (h >= 16'd32768) ? int'(h) - 65536 : int'(h);
      if (a > 16384) begin
        a -= 32768; neg = 1'b1;
      end else if (a < -16384) begin
        a += 32768; neg = 1'b1;
      end
      x = grw_pkg::CORDIC_X0;
      y = 0;
      for (i = 0; i < 14; i++) begin
        if (a >= 0) begin
          t = x - (y >>> i); y = y + (x >>> i); a -= atan_steps[i];
        end else begin
          t = x + (y >>> i); y = y - (x >>> i); a += atan_steps[i];
        end
        x = t;
      end
      if (neg) begin
        x = -x; y = -y;
      end
      c = (x > grw_pkg::Q16_ONE) ? grw_pkg::Q16_ONE :
          (x < -grw_pkg::Q16_ONE) ? -grw_pkg::Q16_ONE : x;
      s = (y > grw_pkg::Q16_ONE) ? grw_pkg::Q16_ONE :
          (y < -grw_pkg::Q16_ONE) ? -grw_pkg::Q16_ONE : y;
    end
    up_x = c > 0;
    up_y = s > 0;
    ux = cell_pitch(c);
    uy = cell_pitch(s);
    dx = boundary_dist(ux, c, int'(sx), up_x);
    dy = boundary_dist(uy, s, int'(sy), up_y);
    cx = int'(sx) >>> 8;
    cy = int'(sy) >>> 8;
    stx = up_x ? 1 : -1;
    sty = up_y ? 1 : -1;
    // low edge truncates toward zero
    v = int'(sx) - r * 256; lo_x = v / 256;
    v = int'(sy) - r * 256; lo_y = v / 256;
    hi_x = cx + r;
    hi_y = cy + r;
    cnt = 0;
    while (cnt < grw_pkg::CELL_CAP && cx >= lo_x && cy >= lo_y && cx < hi_x && cy < hi_y) begin
      w = (dx < dy) ? dx : dy;
      idx = cy * gw + cx;
      pred.cell_index     = idx[grw_pkg::INDEX_W-1:0];
      pred.segment_length = (w > int'(grw_pkg::SEG_MAX)) ? grw_pkg::SEG_MAX
                                                          : w[grw_pkg::SEG_W-1:0];
      pred.last_cell      = 1'b0;
      cells_due = {cells_due, pred};
      dx -= w;
      dy -= w;
      if (dx == 0) begin
        dx = ux; cx += stx;
      end
      if (dy == 0) begin
        dy = uy; cy += sty;
      end
      cnt++;
    end
    if (cnt > 0) cells_due[cells_due.size()-1].last_cell = 1'b1;
  endtask

  // one ray transfer; a gap owed from the last burst comes first
  task automatic send_ray(input logic [grw_pkg::COORD_W-1:0] sx,
                          input logic [grw_pkg::COORD_W-1:0] sy,
                          input logic [grw_pkg::HEAD_W-1:0] h);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      burst_left = $urandom_range(0, 8);
      ray_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
    ray_if.valid   <= 1'b1;
    ray_if.start_x <= sx;
    ray_if.start_y <= sy;
    ray_if.heading <= h;
    @(posedge clk);
    while (!ray_if.ready) @(posedge clk);
    walk_ray(sx, sy, h);
  endtask

  // waits until every cell has arrived and the block has settled
  task automatic drain_cells();
    ray_if.valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [grw_pkg::GW_W-1:0] val);
    drain_cells();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == grw_pkg::REG_GRID_WIDTH) grid_width_q = val;
    else ray_range_q = val[grw_pkg::RANGE_W-1:0];
  endtask

  function automatic logic [grw_pkg::HEAD_W-1:0] rand_heading();
    if ($urandom_range(0, 7) == 0) return {2'($urandom_range(0, 3)), 14'd0};
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [grw_pkg::COORD_W-1:0] rand_coord();
    logic [grw_pkg::COORD_W-1:0] v;
    v = 18'($urandom_range(0, 262143));
    // sometimes right on a cell boundary
    if ($urandom_range(0, 5) == 0) v[7:0] = 8'd0;
    return v;
  endfunction

  // exact axis and diagonal headings, and headings just off the x axis
  task automatic test_axis_headings();
    send_ray(18'h01080, 18'h01080, 16'd0);
    send_ray(18'h01080, 18'h01080, 16'd16384);
    send_ray(18'h01080, 18'h01080, 16'd32768);
    send_ray(18'h01080, 18'h01080, 16'd49152);
    send_ray(18'h01040, 18'h010c0, 16'd8192);
    send_ray(18'h01040, 18'h010c0, 16'd40960);
    send_ray(18'h01040, 18'h010c0, 16'd1);
    send_ray(18'h01040, 18'h010c0, 16'd65535);
  endtask

  // origin on a boundary: stepping down gives a zero-length cell, stepping up does not
  task automatic test_boundary_origins();
    send_ray(18'h00500, 18'h00533, 16'd32768);
    send_ray(18'h00533, 18'h00500, 16'd49152);
    send_ray(18'h00500, 18'h00500, 16'd45000);
    send_ray(18'h00500, 18'h00500, 16'd12000);
  endtask

  // coordinate extremes, near the origin too (negative cells)
  task automatic test_field_extremes();
    send_ray(18'h00000, 18'h00000, 16'd0);
    send_ray(18'h00000, 18'h00000, 16'd40000);
    send_ray(18'h3ffff, 18'h3ffff, 16'hffff);
    send_ray(18'h3ffff, 18'h3ffff, 16'h2aaa);
    send_ray(18'h3ffff, 18'h00000, 16'h5555);
    send_ray(18'h00000, 18'h3ffff, 16'haaaa);
  endtask

  // register extremes: zero range, saturation, width one and zero, index wrap
  task automatic test_config_extremes();
    write_reg(grw_pkg::REG_RAY_RANGE, 11'd0);
    send_ray(18'h01080, 18'h01080, 16'd3000);
    write_reg(grw_pkg::REG_RAY_RANGE, 11'd31);
    write_reg(grw_pkg::REG_GRID_WIDTH, 11'd2047);
    send_ray(18'h3ff80, 18'h3ff80, 16'd8192);
    send_ray(18'h00010, 18'h00010, 16'd36000);
    write_reg(grw_pkg::REG_GRID_WIDTH, 11'd1);
    write_reg(grw_pkg::REG_RAY_RANGE, 11'd1);
    send_ray(18'h01080, 18'h01080, 16'd7000);
    write_reg(grw_pkg::REG_GRID_WIDTH, 11'd0);
    send_ray(18'h01080, 18'h01080, 16'd20000);
  endtask

  task automatic test_random_walks(input int n);
    repeat (n) send_ray(rand_coord(), rand_coord(), rand_heading());
  endtask

  // receiver holds off while rays keep coming, so the block backs up
  task automatic test_output_backpressure();
    drain_cells();
    hold_req = 1'b1;
    repeat (12) send_ray(rand_coord(), rand_coord(), rand_heading());
  endtask

  // receiver: random stall patterns, stretches of always-ready, one long hold
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    cell_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        cell_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(20, 150);
        end
        left--;
        case (mode)
          0:       cell_if.ready <= 1'b1;
          1:       cell_if.ready <= ($urandom_range(0, 3) != 0);
          default: cell_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // cell checker: every transfer against the oldest prediction
  always @(posedge clk) begin
    cell_t want;
    if (rst_n === 1'b1 && cell_if.valid && cell_if.ready) begin
      if (cells_due.size() == 0) begin
        $display("%0t: unexpected cell index %0d seg %0d last %0b", $time,
                 cell_if.cell_index, cell_if.segment_length, cell_if.last_cell);
        errors++;
      end else begin
        want = cells_due.pop_front();
        if (cell_if.cell_index !== want.cell_index) begin
          $display("%0t: cell_index expected %0d actual %0d", $time,
                   want.cell_index, cell_if.cell_index);
          errors++;
        end
        if (cell_if.segment_length !== want.segment_length) begin
          $display("%0t: segment_length expected %0d actual %0d", $time,
                   want.segment_length, cell_if.segment_length);
          errors++;
        end
        if (cell_if.last_cell !== want.last_cell) begin
          $display("%0t: last_cell expected %0b actual %0b", $time,
                   want.last_cell, cell_if.last_cell);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((ray_if.valid && ray_if.ready) || (cell_if.valid && cell_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= grw_pkg::REG_GRID_WIDTH;
    cfg_data       <= '0;
    ray_if.valid   <= 1'b0;
    ray_if.start_x <= '0;
    ray_if.start_y <= '0;
    ray_if.heading <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values first: width 1024, range 8
    test_axis_headings();
    test_boundary_origins();
    test_field_extremes();
    test_config_extremes();

    write_reg(grw_pkg::REG_GRID_WIDTH, 11'd1024);
    write_reg(grw_pkg::REG_RAY_RANGE, 11'd16);
    test_random_walks(110);
    write_reg(grw_pkg::REG_GRID_WIDTH, 11'($urandom_range(1, 2047)));
    write_reg(grw_pkg::REG_RAY_RANGE, 11'($urandom_range(1, 8)));
    test_random_walks(110);
    test_output_backpressure();
    write_reg(grw_pkg::REG_GRID_WIDTH, 11'd1);
    write_reg(grw_pkg::REG_RAY_RANGE, 11'd1);
    test_random_walks(80);
    write_reg(grw_pkg::REG_GRID_WIDTH, 11'($urandom_range(0, 2047)));
    write_reg(grw_pkg::REG_RAY_RANGE, 11'($urandom_range(0, 31)));
    test_random_walks(110);

    drain_cells();
    if (errors == 0 && cells_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ grid_ray_cell_walker_top.f @@
rtl/core/grw_pkg.sv
rtl/core/grw_if.sv
rtl/core/grw_recip.sv
rtl/core/grid_ray_cell_walker_top.sv
tb/grid_ray_cell_walker_top_test.sv
